### hdl/qcmr_pkg.sv
package qcmr_pkg;

  localparam int BIAS_SHIFT = 8;
  localparam int ACC_W      = 32;
  localparam int WORK_W     = 64;
  localparam int SH_W       = 7;
  localparam int MUL_A_W    = 33;
  localparam int MUL_P_W    = 2 * MUL_A_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 8;

  localparam int ACT_LSB    = 0;
  localparam int WGT_LSB    = 8;
  localparam int BIAS_LSB   = 16;
  localparam int RMULT_LSB  = 80;
  localparam int RSHIFT_LSB = 112;
  localparam int PMULT_LSB  = 118;
  localparam int PSHIFT_LSB = 150;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRELU_ENABLE = 2'd0,
    CFG_PAD_VALUE    = 2'd1,
    CFG_OUT_ZERO_ADD = 2'd2
  } cfg_idx_t;

  function automatic logic [WORK_W-1:0] round_rshift(input logic [WORK_W-1:0] v,
                                                     input logic [SH_W-1:0] s);
    logic [WORK_W-1:0] t;
    logic [WORK_W-1:0] r;
    t = v + (WORK_W'(1) << (s - SH_W'(1)));
    if (s == '0) begin
      r = v;
    end else if (s >= SH_W'(WORK_W)) begin
      r = '0;
    end else begin
      r = WORK_W'($signed(t) >>> s);
    end
    return r;
  endfunction

  function automatic logic [OUT_DATA_W-1:0] clamp8(input logic [WORK_W-1:0] q);
    logic [OUT_DATA_W-1:0] r;
    if ($signed(q) < -64'sd128) begin
      r = 8'h80;
    end else if ($signed(q) > 64'sd127) begin
      r = 8'h7F;
    end else begin
      r = q[OUT_DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/qcmr_mul.sv
module qcmr_mul (
  input  logic                                 clk,
  input  logic signed [qcmr_pkg::MUL_A_W-1:0] a,
  input  logic signed [qcmr_pkg::MUL_A_W-1:0] b,
  output logic signed [qcmr_pkg::MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/quantized_conv_mac_requant.sv
// Multiply-accumulate and requantize for one output of an int8 convolution.
// Input channel s_axis_*: one word per tap. tlast marks the last tap of a
// window, tuser marks a padded tap (the pad_value register replaces the
// activation). Output channel m_axis_*: one int8 result per window.
// Configuration channel cfg_*: index 0 prelu_enable, 1 pad_value,
// 2 out_zero_add; other indexes are ignored. cfg_ready is always high.
// One shared 33x33 signed multiplier with a registered product serves every
// multiply, under a small sequencer; s_axis_tready is high only when idle.
// An ordinary tap is multiplied and accumulated, then the sequencer returns
// to idle. A last tap reaches the output register in these steps: multiply,
// accumulate, bias, then each 64x32 multiply (the PReLU one first, when it
// applies) as two partial products plus a sum, then a rounding shift, then
// zero-point add and clamp. The result stays in an output register; the
// next window's taps are accepted while it waits. If the receiver stalls and
// a new result is ready, the sequencer holds in its final step until the
// register frees. Reset clears the configuration registers, the
// accumulator and the output valid, and returns the sequencer to idle.
module quantized_conv_mac_requant (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // activation, weight_val, bias_val, requant_mult, requant_shift,
  // neg_mult, neg_shift, zero fill
  input  logic [qcmr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tlast,
  // is_padding
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_value
  output logic [qcmr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcmr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_TAP_MUL = 8'b0000_0010,
    S_TAP_ACC = 8'b0000_0100,
    S_BIAS    = 8'b0000_1000,
    S_MUL_LO  = 8'b0001_0000,
    S_MUL_HI  = 8'b0010_0000,
    S_MUL_SUM = 8'b0100_0000,
    S_RND     = 8'b1000_0000
  } state_t;

  typedef enum logic [0:0] {
    S_OUT_NONE = 1'b0,
    S_OUT_WAIT = 1'b1
  } out_state_t;

  state_t     state;
  state_t     state_next;
  out_state_t fin;

  logic                               prelu_enable;
  logic signed [7:0]                  pad_value;
  logic signed [8:0]                  out_zero_add;

  logic signed [7:0]                  act;
  logic signed [7:0]                  wgt;
  logic                               last;
  logic [qcmr_pkg::WORK_W-1:0]        bias;
  logic signed [31:0]                 rmult;
  logic [5:0]                         rshift;
  logic signed [31:0]                 pmult;
  logic [5:0]                         pshift;

  logic [qcmr_pkg::ACC_W-1:0]         acc;
  logic [qcmr_pkg::ACC_W-1:0]         acc_sum;
  logic [qcmr_pkg::WORK_W-1:0]        work;
  logic [qcmr_pkg::WORK_W-1:0]        work_biased;
  logic [qcmr_pkg::WORK_W-1:0]        partial;
  logic [qcmr_pkg::WORK_W-1:0]        qval;
  logic                               prelu_phase;
  logic [qcmr_pkg::SH_W-1:0]          shamt;
  logic signed [31:0]                 mult_sel;

  logic signed [qcmr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [qcmr_pkg::MUL_A_W-1:0] mul_b;
  logic signed [qcmr_pkg::MUL_P_W-1:0] mul_p;

  logic s_acc;
  logic out_free;
  logic out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = (state == S_RND) && !prelu_phase && (fin == S_OUT_WAIT) && out_free;

  assign acc_sum     = acc + mul_p[qcmr_pkg::ACC_W-1:0];
  assign work_biased = ({{(qcmr_pkg::WORK_W - qcmr_pkg::ACC_W){acc[qcmr_pkg::ACC_W-1]}}, acc}
                        << qcmr_pkg::BIAS_SHIFT) + bias;
  assign mult_sel    = prelu_phase ? pmult : rmult;
  assign shamt       = prelu_phase ? qcmr_pkg::SH_W'(pshift)
                                   : qcmr_pkg::SH_W'(rshift) + qcmr_pkg::SH_W'(qcmr_pkg::BIAS_SHIFT);
  assign qval        = work + qcmr_pkg::WORK_W'(out_zero_add);

  always_comb begin
    mul_a = qcmr_pkg::MUL_A_W'($signed(work[63:32]));
    mul_b = qcmr_pkg::MUL_A_W'(mult_sel);
    unique case (state)
      S_TAP_MUL: begin
        mul_a = qcmr_pkg::MUL_A_W'(act);
        mul_b = qcmr_pkg::MUL_A_W'(wgt);
      end
      S_MUL_LO: begin
        mul_a = $signed({1'b0, work[31:0]});
      end
      default: begin
      end
    endcase
  end

  qcmr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (s_acc) state_next = S_TAP_MUL;
      S_TAP_MUL: state_next = S_TAP_ACC;
      S_TAP_ACC: state_next = last ? S_BIAS : S_IDLE;
      S_BIAS:    state_next = S_MUL_LO;
      S_MUL_LO:  state_next = S_MUL_HI;
      S_MUL_HI:  state_next = S_MUL_SUM;
      S_MUL_SUM: state_next = S_RND;
      S_RND:     state_next = prelu_phase ? S_MUL_LO : S_RND;
      default:   state_next = S_IDLE;
    endcase
    if (out_load) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prelu_enable <= 1'b0;
      pad_value    <= '0;
      out_zero_add <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qcmr_pkg::CFG_PRELU_ENABLE: prelu_enable <= cfg_data[0];
        qcmr_pkg::CFG_PAD_VALUE:    pad_value    <= cfg_data[7:0];
        qcmr_pkg::CFG_OUT_ZERO_ADD: out_zero_add <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      act    <= s_axis_tuser ? pad_value : s_axis_tdata[qcmr_pkg::ACT_LSB +: 8];
      wgt    <= s_axis_tdata[qcmr_pkg::WGT_LSB +: 8];
      last   <= s_axis_tlast;
      bias   <= s_axis_tdata[qcmr_pkg::BIAS_LSB +: qcmr_pkg::WORK_W];
      rmult  <= s_axis_tdata[qcmr_pkg::RMULT_LSB +: 32];
      rshift <= s_axis_tdata[qcmr_pkg::RSHIFT_LSB +: 6];
      pmult  <= s_axis_tdata[qcmr_pkg::PMULT_LSB +: 32];
      pshift <= s_axis_tdata[qcmr_pkg::PSHIFT_LSB +: 6];
    end
    unique case (state)
      S_BIAS:    work    <= work_biased;
      S_MUL_HI:  partial <= mul_p[qcmr_pkg::WORK_W-1:0];
      S_MUL_SUM: work    <= partial + {mul_p[31:0], 32'd0};
      S_RND:     if (fin == S_OUT_NONE) work <= qcmr_pkg::round_rshift(work, shamt);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fin           <= S_OUT_NONE;
      acc           <= '0;
      prelu_phase   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_TAP_ACC: acc <= acc_sum;
        S_BIAS: begin
          acc         <= '0;
          prelu_phase <= prelu_enable && work_biased[qcmr_pkg::WORK_W-1];
        end
        S_RND: begin
          if (prelu_phase) begin
            prelu_phase <= 1'b0;
          end else if (fin == S_OUT_NONE) begin
            fin <= S_OUT_WAIT;
          end else if (out_free) begin
            fin           <= S_OUT_NONE;
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= qcmr_pkg::clamp8(qval);
          end
        end
        default: begin
        end
      endcase
    end
  end

  ap_tap_turn: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast)
      |=> !s_axis_tready ##1 !s_axis_tready ##1 s_axis_tready)
    else $error("ordinary tap did not return to idle in three cycles");

  ap_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_RND && fin == S_OUT_WAIT))
    else $error("result presented outside the final step");

  ap_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_LO || state == S_MUL_HI || state == S_MUL_SUM || state == S_RND)
      |-> (acc == '0))
    else $error("accumulator not cleared during the tail");

endmodule
